FILE: src/fasr_pkg.sv
// Shared constants and types of the frame advantage sleep recommender.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fasr_pkg;

    // Default store sizes handed to the top level parameters.
    localparam int WINDOW_SIZE_DEF  = 32;
    localparam int HISTORY_SIZE_DEF = 8;

    // Field widths.
    localparam int FRAME_W   = 16;
    localparam int ADV_W     = 8;
    localparam int BITS_W    = 64;
    localparam int SLEEP_W   = 6;
    localparam int OUTCOME_W = 2;
    localparam int WORD_W    = 2 * ADV_W;

    typedef logic [OUTCOME_W-1:0] outcome_t;
    typedef logic [SLEEP_W-1:0]   sleep_t;

    // Item kinds carried in tuser.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result outcome codes.
    localparam outcome_t OUTCOME_RECOMMENDED = 2'd0;
    localparam outcome_t OUTCOME_NOT_AHEAD   = 2'd1;
    localparam outcome_t OUTCOME_BELOW_MIN   = 2'd2;
    localparam outcome_t OUTCOME_NOT_IDLE    = 2'd3;

    // Register indexes and reset values.
    localparam logic REG_MIN_SLEEP = 1'b0;
    localparam logic REG_MAX_SLEEP = 1'b1;
    localparam sleep_t MIN_SLEEP_RST = 6'd3;
    localparam sleep_t MAX_SLEEP_RST = 6'd9;

endpackage

`default_nettype wire

FILE: src/frame_advantage_sleep_recommender.sv
// Frame advantage sleep recommender: records per-frame advantages and inputs,
// answers sleep queries. Uses fasr_pkg, fasr_div and fasr_store.
// A record passes the divider wait and write-back states before the next input
// transfer; the wait holds while a divider by a non-power-of-two size is busy.
// A query that is not ahead loads its output register from idle; else it waits
// for the dividers and, for an idle scan, the scan and tail states.
// The next item follows the load; a held output register stalls it.
// Reset clears all stores at once through valid bits; no clearing pass.
`default_nettype none

module frame_advantage_sleep_recommender #(
    parameter int WINDOW_SIZE  = fasr_pkg::WINDOW_SIZE_DEF,
    parameter int HISTORY_SIZE = fasr_pkg::HISTORY_SIZE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: frame_number[15:0], local_advantage[23:16],
    // remote_advantage[31:24], input_bits[95:32].
    input  wire logic [95:0] s_tdata,
    // s_tuser: op[0], require_idle[1].
    input  wire logic [1:0]  s_tuser,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: sleep_count[5:0], zero padding[7:6].
    output logic [7:0]       m_tdata,
    // m_tuser: outcome[1:0].
    output logic [1:0]       m_tuser,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int WIDX_W = $clog2(WINDOW_SIZE);
    localparam int HIDX_W = $clog2(HISTORY_SIZE);
    // Running sums span WINDOW_SIZE entries of 8-bit signed values.
    localparam int SUM_W  = WIDX_W + 9;
    // The divider handles both the frame number and the rounded difference.
    localparam int NUM_W  = (SUM_W + 1 > fasr_pkg::FRAME_W) ? SUM_W + 1 : fasr_pkg::FRAME_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_WR   = 6'b000100,
        ST_SCAN = 6'b001000,
        ST_TAIL = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    fasr_pkg::sleep_t min_sleep_reg;
    fasr_pkg::sleep_t max_sleep_reg;
    logic             cfg_wr;

    // Latched item payload.
    logic                                  op_reg;
    logic                                  req_idle_reg;
    logic signed [fasr_pkg::ADV_W-1:0]     la_reg;
    logic signed [fasr_pkg::ADV_W-1:0]     ra_reg;
    logic [fasr_pkg::BITS_W-1:0]           bits_reg;

    // Running window sums.
    logic signed [SUM_W-1:0] local_sum_reg;
    logic signed [SUM_W-1:0] remote_sum_reg;
    logic signed [SUM_W:0]   diff;

    // History scan.
    logic [HIDX_W-1:0]           scan_reg;
    logic [fasr_pkg::BITS_W-1:0] ref_reg;
    logic                        mismatch_reg;

    // Pending result and output register.
    fasr_pkg::sleep_t   res_sleep_reg;
    fasr_pkg::outcome_t res_outcome_reg;
    fasr_pkg::sleep_t   out_sleep_reg;
    fasr_pkg::outcome_t out_outcome_reg;
    logic               out_valid_reg;

    // Datapath nets.
    logic                        in_xfer;
    logic                        out_load;
    logic [NUM_W-1:0]            wdiv_num;
    logic                        wdiv_busy;
    logic [NUM_W-1:0]            wdiv_quo;
    logic [WIDX_W-1:0]           wdiv_rem;
    logic                        hdiv_busy;
    logic [NUM_W-1:0]            hdiv_quo;
    logic [HIDX_W-1:0]           hdiv_rem;
    logic [NUM_W-2:0]            sleep_raw;
    fasr_pkg::sleep_t            sleep_clamped;
    logic                        below_min;
    logic [fasr_pkg::WORD_W-1:0] win_rdata;
    logic [fasr_pkg::BITS_W-1:0] hist_rdata;
    logic signed [fasr_pkg::ADV_W-1:0] old_la;
    logic signed [fasr_pkg::ADV_W-1:0] old_ra;
    logic                        win_we;
    logic                        tail_mismatch;

    // ------------------------------------------------------------------
    // Configuration port: writes complete in the access phase, reads are
    // answered combinationally. Only paddr[2] selects the register.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sleep_reg <= fasr_pkg::MIN_SLEEP_RST;
            max_sleep_reg <= fasr_pkg::MAX_SLEEP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                fasr_pkg::REG_MIN_SLEEP: min_sleep_reg <= pwdata[fasr_pkg::SLEEP_W-1:0];
                fasr_pkg::REG_MAX_SLEEP: max_sleep_reg <= pwdata[fasr_pkg::SLEEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            fasr_pkg::REG_MIN_SLEEP: prdata = {26'd0, min_sleep_reg};
            fasr_pkg::REG_MAX_SLEEP: prdata = {26'd0, max_sleep_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Dividers. The window divider yields the window index on a record and
    // floor((D + W) / W) on a query; halving that gives the rounded sleep.
    // The history divider yields the history index.
    // ------------------------------------------------------------------
    assign in_xfer = s_tvalid && s_tready;
    assign diff    = {remote_sum_reg[SUM_W-1], remote_sum_reg}
                   - {local_sum_reg[SUM_W-1], local_sum_reg};
    assign wdiv_num = (s_tuser[0] == fasr_pkg::OP_QUERY)
                    ? NUM_W'(diff) + NUM_W'(WINDOW_SIZE)
                    : NUM_W'(s_tdata[15:0]);

    fasr_div #(
        .DIVISOR (WINDOW_SIZE),
        .NUM_W   (NUM_W)
    ) u_wdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .num   (wdiv_num),
        .busy  (wdiv_busy),
        .quo   (wdiv_quo),
        .rem   (wdiv_rem)
    );

    fasr_div #(
        .DIVISOR (HISTORY_SIZE),
        .NUM_W   (NUM_W)
    ) u_hdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .num   (NUM_W'(s_tdata[15:0])),
        .busy  (hdiv_busy),
        .quo   (hdiv_quo),
        .rem   (hdiv_rem)
    );

    assign sleep_raw     = wdiv_quo[NUM_W-1:1];
    assign below_min     = sleep_raw < (NUM_W-1)'(min_sleep_reg);
    assign sleep_clamped = (sleep_raw < (NUM_W-1)'(max_sleep_reg))
                         ? sleep_raw[fasr_pkg::SLEEP_W-1:0] : max_sleep_reg;

    // ------------------------------------------------------------------
    // Stores. The window memory is read every cycle at the divider
    // remainder, so the old entry is ready in the write-back state. The
    // history memory is read at the scan counter.
    // ------------------------------------------------------------------
    assign win_we = (state_reg == ST_WR);

    fasr_store #(
        .WINDOW_SIZE  (WINDOW_SIZE),
        .HISTORY_SIZE (HISTORY_SIZE)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .win_addr   (wdiv_rem),
        .win_we     (win_we),
        .win_wdata  ({ra_reg, la_reg}),
        .win_rdata  (win_rdata),
        .hist_raddr (scan_reg),
        .hist_waddr (hdiv_rem),
        .hist_we    (win_we),
        .hist_wdata (bits_reg),
        .hist_rdata (hist_rdata)
    );

    assign old_la = $signed(win_rdata[fasr_pkg::ADV_W-1:0]);
    assign old_ra = $signed(win_rdata[fasr_pkg::WORD_W-1:fasr_pkg::ADV_W]);
    assign tail_mismatch = mismatch_reg || (hist_rdata != ref_reg);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser[0] == fasr_pkg::OP_QUERY && !(diff > 0))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (!wdiv_busy && !hdiv_busy)
                begin
                    if (op_reg == fasr_pkg::OP_RECORD)
                    begin
                        state_next = ST_WR;
                    end
                    else if (!below_min && req_idle_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_reg == HIDX_W'(HISTORY_SIZE - 1))
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: state, sums, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            local_sum_reg  <= '0;
            remote_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WR)
            begin
                local_sum_reg  <= local_sum_reg + SUM_W'(la_reg) - SUM_W'(old_la);
                remote_sum_reg <= remote_sum_reg + SUM_W'(ra_reg) - SUM_W'(old_ra);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg          <= s_tuser[0];
            req_idle_reg    <= s_tuser[1];
            la_reg          <= $signed(s_tdata[23:16]);
            ra_reg          <= $signed(s_tdata[31:24]);
            bits_reg        <= s_tdata[95:32];
            scan_reg        <= '0;
            res_sleep_reg   <= '0;
            res_outcome_reg <= fasr_pkg::OUTCOME_NOT_AHEAD;
        end

        if (state_reg == ST_DIV && !wdiv_busy && !hdiv_busy)
        begin
            if (below_min)
            begin
                res_sleep_reg   <= '0;
                res_outcome_reg <= fasr_pkg::OUTCOME_BELOW_MIN;
            end
            else
            begin
                res_sleep_reg   <= sleep_clamped;
                res_outcome_reg <= fasr_pkg::OUTCOME_RECOMMENDED;
            end
        end

        // The history read is registered and answers in the cycle after its address: entry 0
        // becomes the reference, later entries are compared against it.
        if (state_reg == ST_SCAN)
        begin
            if (scan_reg == '0)
            begin
                mismatch_reg <= 1'b0;
            end
            if (scan_reg == HIDX_W'(1))
            begin
                ref_reg <= hist_rdata;
            end
            if (scan_reg > HIDX_W'(1))
            begin
                mismatch_reg <= mismatch_reg || (hist_rdata != ref_reg);
            end
            if (scan_reg != HIDX_W'(HISTORY_SIZE - 1))
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end

        if (state_reg == ST_TAIL && tail_mismatch)
        begin
            res_sleep_reg   <= '0;
            res_outcome_reg <= fasr_pkg::OUTCOME_NOT_IDLE;
        end

        if (out_load)
        begin
            out_sleep_reg   <= res_sleep_reg;
            out_outcome_reg <= res_outcome_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_sleep_reg};
    assign m_tuser  = out_outcome_reg;

endmodule

`default_nettype wire

FILE: src/fasr_div.sv
// Divider by a fixed constant: shift and mask for a power of two, otherwise a
// reciprocal multiplication that registers the quotient, then the remainder. Uses fasr_pkg.
`default_nettype none

module fasr_div #(
    parameter int DIVISOR = fasr_pkg::WINDOW_SIZE_DEF,
    parameter int NUM_W   = fasr_pkg::FRAME_W
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [NUM_W-1:0]             num,
    output logic                              busy,
    output logic [NUM_W-1:0]                  quo,
    output logic [$clog2(DIVISOR)-1:0]        rem
);

    localparam int IDX_W = $clog2(DIVISOR);
    localparam bit POW2  = ((DIVISOR & (DIVISOR - 1)) == 0);

    generate
        if (POW2) begin : g_shift
            logic [NUM_W-1:0] quo_reg;
            logic [IDX_W-1:0] rem_reg;

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    quo_reg <= num >> IDX_W;
                    rem_reg <= num[IDX_W-1:0];
                end
            end

            assign busy = 1'b0;
            assign quo  = quo_reg;
            assign rem  = rem_reg;
        end else begin : g_recip
            // With S = NUM_W + IDX_W and M = ceil(2^S / DIVISOR), the top bits
            // of num * M give the exact quotient for every num below 2^NUM_W.
            localparam int SH_W   = NUM_W + IDX_W;
            localparam int REC_W  = NUM_W + 2;
            localparam int PROD_W = SH_W + NUM_W;
            localparam logic [63:0] RECIP = ((64'd1 << SH_W) + 64'(DIVISOR - 1))
                                          / 64'(DIVISOR);
            localparam logic [REC_W-1:0] REC_V = REC_W'(RECIP);
            localparam logic [IDX_W-1:0] DIV_V = IDX_W'(DIVISOR);

            logic [PROD_W-1:0] prod;
            logic [IDX_W-1:0]  low_next;
            logic [NUM_W-1:0]  num_reg;
            logic [NUM_W-1:0]  quo_reg;
            logic [IDX_W-1:0]  rem_reg;
            logic              busy_reg;

            assign prod = PROD_W'(num) * PROD_W'(REC_V);
            // The remainder is below the divisor, so its low bits are enough.
            assign low_next = num_reg[IDX_W-1:0] - IDX_W'(quo_reg[IDX_W-1:0] * DIV_V);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    busy_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    num_reg <= num;
                    quo_reg <= prod[PROD_W-1:SH_W];
                end
                if (busy_reg)
                begin
                    rem_reg <= low_next;
                end
            end

            assign busy = busy_reg;
            assign quo  = quo_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

FILE: src/fasr_store.sv
// Advantage window memory and input history memory, each with one write and
// one registered read port and per-entry valid bits. Uses fasr_pkg.
`default_nettype none

module fasr_store #(
    parameter int WINDOW_SIZE  = fasr_pkg::WINDOW_SIZE_DEF,
    parameter int HISTORY_SIZE = fasr_pkg::HISTORY_SIZE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [$clog2(WINDOW_SIZE)-1:0]    win_addr,
    input  wire logic                              win_we,
    input  wire logic [fasr_pkg::WORD_W-1:0]       win_wdata,
    output logic [fasr_pkg::WORD_W-1:0]            win_rdata,
    input  wire logic [$clog2(HISTORY_SIZE)-1:0]   hist_raddr,
    input  wire logic [$clog2(HISTORY_SIZE)-1:0]   hist_waddr,
    input  wire logic                              hist_we,
    input  wire logic [fasr_pkg::BITS_W-1:0]       hist_wdata,
    output logic [fasr_pkg::BITS_W-1:0]            hist_rdata
);

    logic [fasr_pkg::WORD_W-1:0] win_mem [WINDOW_SIZE];
    logic [fasr_pkg::BITS_W-1:0] hist_mem [HISTORY_SIZE];
    logic [WINDOW_SIZE-1:0]      win_valid_reg;
    logic [HISTORY_SIZE-1:0]     hist_valid_reg;
    logic [fasr_pkg::WORD_W-1:0] win_q_reg;
    logic [fasr_pkg::BITS_W-1:0] hist_q_reg;
    logic                        win_qv_reg;
    logic                        hist_qv_reg;

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg  <= '0;
            hist_valid_reg <= '0;
            win_qv_reg     <= 1'b0;
            hist_qv_reg    <= 1'b0;
        end
        else
        begin
            win_qv_reg  <= win_valid_reg[win_addr];
            hist_qv_reg <= hist_valid_reg[hist_raddr];
            if (win_we)
            begin
                win_valid_reg[win_addr] <= 1'b1;
            end
            if (hist_we)
            begin
                hist_valid_reg[hist_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_q_reg  <= win_mem[win_addr];
        hist_q_reg <= hist_mem[hist_raddr];
        if (win_we)
        begin
            win_mem[win_addr] <= win_wdata;
        end
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
    end

    assign win_rdata  = win_qv_reg  ? win_q_reg  : '0;
    assign hist_rdata = hist_qv_reg ? hist_q_reg : '0;

endmodule

`default_nettype wire
